>>> hw/rtl/ois_pkg.sv
// shared types and constants for the ordered id set
`timescale 1ns / 1ps
package ois_pkg;

  // store depth and widths; only the index width is derived from the depth
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int ID_W     = 32;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 3;

  localparam logic [ID_W-1:0] INVALID_ID = '1;

  // requested action
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 3'd0,
    ACT_REMOVE   = 3'd1,
    ACT_CONTAINS = 3'd2,
    ACT_SNAPSHOT = 3'd3,
    ACT_CLEAR    = 3'd4
  } act_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_INVALID  = 3'd1,
    STAT_EXISTS   = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_NOSPACE  = 3'd5
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SCAN,
    SQ_SHIFT,
    SQ_SNAP
  } seq_state_t;

  // one result beat
  typedef struct packed {
    status_t          status;
    logic             found;
    logic [CNT_W-1:0] count;
    logic [ID_W-1:0]  id;
    logic             present;
    logic             last;
  } res_t;

endpackage

>>> hw/rtl/ordered_id_set_top.sv
// ordered id set: add, contains and remove scan the held entries in order, stopping at a match
// remove with a hit then shifts each later entry down one slot to close the gap
// snapshot gives one beat per cycle; other actions answer straight from the idle state
// one item at a time; the store's single read port sets the one-entry-per-cycle pace
// each result beat holds out_valid for one cycle; the receiver cannot stall the block
// reset empties the set; store contents are left as they are and never read unwritten
`timescale 1ns / 1ps
module ordered_id_set_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [ois_pkg::ACT_W-1:0]  in_action,
  input  logic [ois_pkg::ID_W-1:0]   in_user_id,
  input  logic [ois_pkg::ID_W-1:0]   in_snapshot_capacity,
  output logic                       out_valid,
  output logic [ois_pkg::STAT_W-1:0] out_status,
  output logic                       out_found,
  output logic [ois_pkg::CNT_W-1:0]  out_total_count,
  output logic [ois_pkg::ID_W-1:0]   out_id_out,
  output logic                       out_entry_present,
  output logic                       out_last
);
  import ois_pkg::*;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ID_W-1:0]  ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ID_W-1:0]  ram_rdata;
  logic             res_valid;
  res_t             res;
  logic             out_valid_r;
  res_t             out_res_r;

  // id store
  ois_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  ois_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_action),
    .user_id   (in_user_id),
    .snap_cap  (in_snapshot_capacity),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_found         = out_res_r.found;
  assign out_total_count   = out_res_r.count;
  assign out_id_out        = out_res_r.id;
  assign out_entry_present = out_res_r.present;
  assign out_last          = out_res_r.last;

`ifndef SYNTHESIS
  // count never exceeds the store depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total_count <= CNT_W'(CAPACITY)))
    else $error("result count above capacity");

  // snapshot entries only come with ok status and no contains answer
  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_present |-> (out_status == STAT_OK) && !out_found)
    else $error("snapshot beat with bad status");

  // a snapshot stream has no gaps until its last beat
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_entry_present)
    else $error("gap in snapshot stream");

  // clear answers next cycle with an empty set
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ACT_CLEAR) |=>
      out_valid && out_last && (out_total_count == '0))
    else $error("clear did not empty the set");
`endif

endmodule

>>> hw/rtl/ois_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
module ois_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/ois_ctrl.sv
// sequencer with the shared id compare unit: scan, shift-down and snapshot walk
`timescale 1ns / 1ps
module ois_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ois_pkg::ACT_W-1:0]   action,
  input  logic [ois_pkg::ID_W-1:0]    user_id,
  input  logic [ois_pkg::ID_W-1:0]    snap_cap,
  output logic                        busy,
  output logic                        ram_we,
  output logic [ois_pkg::IDX_W-1:0]   ram_waddr,
  output logic [ois_pkg::ID_W-1:0]    ram_wdata,
  output logic [ois_pkg::IDX_W-1:0]   ram_raddr,
  input  logic [ois_pkg::ID_W-1:0]    ram_rdata,
  output logic                        res_valid,
  output ois_pkg::res_t               res
);
  import ois_pkg::*;

  seq_state_t       state_r, state_nxt;
  act_t             act_r, act_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] dst_r, dst_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             hit;
  logic             more;

  // shared compare unit: read data in flight against the held id
  assign hit  = pend_r && (ram_rdata == id_r);
  assign more = idx_r < cnt_r;
  assign busy = (state_r != SQ_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    id_r  <= id_nxt;
    idx_r <= idx_nxt;
    dst_r <= dst_nxt;
  end

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    id_nxt    = id_r;
    idx_nxt   = idx_r;
    dst_nxt   = dst_r;
    pend_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    ram_waddr = cnt_r[IDX_W-1:0];
    ram_wdata = id_r;
    ram_raddr = idx_r[IDX_W-1:0];
    res_valid = 1'b0;
    res       = '{status: STAT_OK, found: 1'b0, count: '0, id: '0,
                  present: 1'b0, last: 1'b1};

    unique case (state_r)
      SQ_IDLE: begin
        if (start) begin
          act_nxt = act_t'(action);
          id_nxt  = user_id;
          idx_nxt = '0;
          unique case (action)
            ACT_ADD, ACT_REMOVE: begin
              if (user_id == INVALID_ID) begin
                res_valid  = 1'b1;
                res.status = STAT_INVALID;
              end else begin
                state_nxt = SQ_SCAN;
              end
            end
            ACT_CONTAINS: begin
              if (user_id == INVALID_ID) begin
                res_valid = 1'b1;
              end else begin
                state_nxt = SQ_SCAN;
              end
            end
            ACT_SNAPSHOT: begin
              if (snap_cap < ID_W'(cnt_r)) begin
                res_valid  = 1'b1;
                res.status = STAT_NOSPACE;
              end else if (cnt_r == '0) begin
                res_valid = 1'b1;
              end else begin
                state_nxt = SQ_SNAP;
              end
            end
            ACT_CLEAR: begin
              cnt_nxt   = '0;
              res_valid = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end

      // linear search, one entry per cycle
      SQ_SCAN: begin
        if (hit) begin
          unique case (act_r)
            ACT_ADD: begin
              res_valid  = 1'b1;
              res.status = STAT_EXISTS;
              state_nxt  = SQ_IDLE;
            end
            ACT_CONTAINS: begin
              res_valid = 1'b1;
              res.found = 1'b1;
              state_nxt = SQ_IDLE;
            end
            default: begin
              // remove: close the gap starting at the matching slot
              dst_nxt   = IDX_W'(idx_r - 1'b1);
              state_nxt = SQ_SHIFT;
            end
          endcase
        end else if (more) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r) begin
          res_valid = 1'b1;
          state_nxt = SQ_IDLE;
          unique case (act_r)
            ACT_ADD: begin
              if (cnt_r >= CNT_W'(CAPACITY)) begin
                res.status = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[IDX_W-1:0];
                ram_wdata = id_r;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            ACT_REMOVE: begin
              res.status = STAT_NOTFOUND;
            end
            default: begin
            end
          endcase
        end
      end

      // move each later entry down by one slot
      SQ_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = dst_r;
          ram_wdata = ram_rdata;
          dst_nxt   = dst_r + 1'b1;
        end
        if (more) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          res_valid = 1'b1;
          state_nxt = SQ_IDLE;
        end
      end

      // stream held ids in order, one beat per cycle
      SQ_SNAP: begin
        if (more) begin
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end
        if (pend_r) begin
          res_valid   = 1'b1;
          res.id      = ram_rdata;
          res.present = 1'b1;
          res.last    = (idx_r == cnt_r);
          if (idx_r == cnt_r) begin
            state_nxt = SQ_IDLE;
          end
        end
      end

      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase

    res.count = cnt_nxt;
  end

endmodule
